>>> design/stlp_pkg.sv
`default_nettype none
package stlp_pkg;

  // Width of the saturating character offset counter
  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  // Depth of the request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Radix constants
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_OCT  = 6'd8;
  localparam logic [5:0] RADIX_DEC  = 6'd10;
  localparam logic [5:0] RADIX_HEX  = 6'd16;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  // Digit value of a character that is not a letter or decimal digit
  localparam logic [6:0] DIGIT_NONE = 7'h7F;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef enum logic {
    OP_MAC,
    OP_EMIT
  } op_t;

  // One request from front to back
  typedef struct packed {
    op_t                    op;
    logic                   fresh;   // accumulator starts from zero
    logic                   neg;
    logic [5:0]             radix;
    logic [5:0]             digit;
    logic [OFFSET_BITS-1:0] offset;
  } req_t;

  // Map a character to its digit value, DIGIT_NONE if it has none
  function automatic logic [6:0] digit_of(logic [7:0] c);
    logic [7:0] d;
    d = 8'(DIGIT_NONE);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d = c - CH_UC_A + 8'd10;
    end
    return d[6:0];
  endfunction

endpackage
`default_nettype wire

>>> design/stlp_front.sv
`default_nettype none
module stlp_front
  import stlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] ch,
  input  wire logic       first,
  input  wire logic [5:0] base,
  input  wire logic       q_ready,
  output logic            q_push,
  output req_t            q_req
);

  phase_t                 phase, phase_next;
  logic [5:0]             radix, radix_next;
  logic                   neg, neg_next;
  logic [OFFSET_BITS-1:0] count, count_next;
  logic                   fresh, fresh_next;

  phase_t                 eff_phase;
  logic [5:0]             eff_radix;
  logic                   eff_neg;
  logic [OFFSET_BITS-1:0] eff_count;
  logic [OFFSET_BITS-1:0] count_adv;
  logic                   eff_fresh;
  logic                   accept;
  logic                   c_ws, c_sign, c_zero, c_x;
  logic                   zero_prefix;
  logic [5:0]             dig_radix;
  logic [6:0]             dig;
  logic                   dig_ok;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Start a new string when first is set
  assign eff_phase = first ? PH_LEAD : phase;
  assign eff_radix = first ? base : radix;
  assign eff_neg   = first ? 1'b0 : neg;
  assign eff_count = first ? '0 : count;
  assign eff_fresh = first ? 1'b1 : fresh;
  assign count_adv = (eff_count == COUNT_MAX) ? eff_count : eff_count + 1'b1;

  // Classify the character
  assign c_ws   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
  assign c_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign c_zero = (ch == CH_ZERO);
  assign c_x    = (ch == CH_LC_X) || (ch == CH_UC_X);
  assign dig    = digit_of(ch);
  assign zero_prefix = c_zero && (eff_radix == RADIX_AUTO || eff_radix == RADIX_HEX);

  // Pick the radix that applies if this character is taken as a digit
  always_comb begin
    dig_radix = eff_radix;
    unique case (eff_phase)
      PH_LEAD, PH_PREFIX: begin
        if (eff_radix == RADIX_AUTO) dig_radix = RADIX_DEC;
      end
      PH_ZERO: begin
        if (eff_radix == RADIX_AUTO) dig_radix = RADIX_OCT;
      end
      default: dig_radix = eff_radix;
    endcase
  end

  assign dig_ok = dig < {1'b0, dig_radix};

  // Next phase
  always_comb begin
    phase_next = eff_phase;
    unique case (eff_phase)
      PH_LEAD: begin
        if (c_ws) phase_next = PH_LEAD;
        else if (c_sign) phase_next = PH_PREFIX;
        else if (zero_prefix) phase_next = PH_ZERO;
        else phase_next = dig_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_PREFIX: begin
        if (zero_prefix) phase_next = PH_ZERO;
        else phase_next = dig_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_ZERO: begin
        if (c_x) phase_next = PH_DIGITS;
        else phase_next = dig_ok ? PH_DIGITS : PH_IDLE;
      end
      PH_DIGITS: phase_next = dig_ok ? PH_DIGITS : PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  // Outputs: request to the back and updates of the string state
  always_comb begin
    radix_next   = eff_radix;
    neg_next     = eff_neg;
    count_next   = eff_count;
    fresh_next   = eff_fresh;
    q_push       = 1'b0;
    q_req.op     = OP_MAC;
    q_req.fresh  = eff_fresh;
    q_req.neg    = eff_neg;
    q_req.radix  = dig_radix;
    q_req.digit  = dig[5:0];
    q_req.offset = eff_count;
    unique case (eff_phase)
      PH_IDLE: begin
        q_push = 1'b0;
      end
      PH_LEAD, PH_PREFIX, PH_ZERO, PH_DIGITS: begin
        if (eff_phase == PH_LEAD && c_ws) begin
          count_next = count_adv;
        end else if (eff_phase == PH_LEAD && c_sign) begin
          neg_next   = (ch == CH_MINUS);
          count_next = count_adv;
        end else if ((eff_phase == PH_LEAD || eff_phase == PH_PREFIX) && zero_prefix) begin
          count_next = count_adv;
        end else if (eff_phase == PH_ZERO && c_x) begin
          radix_next = RADIX_HEX;
          count_next = count_adv;
        end else if (dig_ok) begin
          radix_next = dig_radix;
          count_next = count_adv;
          fresh_next = 1'b0;
          q_push     = accept;
          q_req.op   = OP_MAC;
        end else begin
          radix_next = dig_radix;
          q_push     = accept;
          q_req.op   = OP_EMIT;
        end
      end
      default: q_push = 1'b0;
    endcase
  end

  // Hold the string state between characters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      radix <= '0;
      neg   <= 1'b0;
      count <= '0;
      fresh <= 1'b1;
    end else if (accept) begin
      phase <= phase_next;
      radix <= radix_next;
      neg   <= neg_next;
      count <= count_next;
      fresh <= fresh_next;
    end
  end

endmodule
`default_nettype wire

>>> design/stlp_queue.sv
`default_nettype none
module stlp_queue
  import stlp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  output logic      push_ready,
  input  wire logic pop,
  output logic      head_valid,
  output req_t      head_req
);

  req_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = slots[rd_ptr];

  // Store a request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("request queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> push_ready)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("request popped from an empty queue");

endmodule
`default_nettype wire

>>> design/stlp_back.sv
`default_nettype none
module stlp_back
  import stlp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire req_t         head_req,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [63:0] value,
  output logic [15:0]       end_offset
);

  logic [63:0] acc;
  logic [63:0] acc_base;
  logic [63:0] acc_next;
  logic [63:0] result;
  logic        out_free;

  // Room in the output register when empty or being taken
  assign out_free = !out_valid || out_ready;
  assign pop      = head_valid && (head_req.op == OP_MAC || out_free);

  // One multiply-add per digit
  assign acc_base = head_req.fresh ? '0 : acc;
  assign acc_next = acc_base * {58'd0, head_req.radix} + {58'd0, head_req.digit};
  assign result   = head_req.neg ? (64'd0 - acc_base) : acc_base;

  always_ff @(posedge clk) begin
    if (pop && head_req.op == OP_MAC) begin
      acc <= acc_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_req.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_req.op == OP_EMIT) begin
      value      <= result;
      end_offset <= 16'(head_req.offset);
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    pop && head_req.op == OP_EMIT |=> out_valid)
    else $error("emitted result not presented");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    head_valid && head_req.op == OP_EMIT && out_valid && !out_ready |-> !pop)
    else $error("result overwritten while stalled");

  a_mac_free: assert property (@(posedge clk) disable iff (rst)
    head_valid && head_req.op == OP_MAC |-> pop)
    else $error("digit request stalled");

endmodule
`default_nettype wire

>>> design/string_to_long_parser_top.sv
`default_nettype none
// String-to-integer parser, one character per cycle unless the queue is full.
// Input channel (in_valid/in_ready): one character per request in ch. A request
// with first set starts a new string and samples base (0 detects the radix from
// a 0x or 0 prefix). Leading blanks, one sign and a hex prefix are consumed, then
// digits are accumulated into a 64-bit value that wraps on overflow.
// Output channel (out_valid/out_ready): one request per parsed string, issued for
// the character that ends the parse: the signed value and end_offset, the index
// of that character, saturating.
// Throughput: one character per cycle unless the request queue is full. The front classifies each
// character in the cycle it is accepted; the back does one 64x6 multiply-add per
// digit per cycle.
// Result path: the request for the stopping character passes through the request
// queue, then the output register, before the result is presented.
// Stall: a result waits in the output register while out_ready is low; digits
// behind it keep flowing and further characters are accepted until the 4-entry
// request queue is full, when in_ready drops.
// Reset: rst is synchronous; it empties the queue and output and leaves the
// block waiting for a first character.
module string_to_long_parser_top
  import stlp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    ch,
  input  wire logic          first,
  input  wire logic [5:0]    base,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [63:0] value,
  output logic [15:0]        end_offset
);

  logic q_ready;
  logic q_push;
  req_t q_req;
  logic head_valid;
  req_t head_req;
  logic pop;

  stlp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .first    (first),
    .base     (base),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_req    (q_req)
  );

  stlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_req   (q_req),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  stlp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .end_offset (end_offset)
  );

endmodule
`default_nettype wire

>>> test/tb_string_to_long_parser_top.sv
`default_nettype none
module tb_string_to_long_parser_top;
  import stlp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic [5:0] base;
  } char_req_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        end_offset;
  } parse_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         ch        = 8'd0;
  logic               first     = 1'b0;
  logic [5:0]         base      = 6'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] value;
  logic [15:0]        end_offset;

  char_req_t  pending_chars[$];
  parse_res_t expected_results[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   n_mismatch    = 0;
  int   stall_cycles  = 0;
  int   queued_count  = 0;
  logic in_taken      = 1'b0;
  logic start_next    = 1'b0;
  logic [5:0] cur_base = 6'd0;

  // Parser state as the block should hold it
  phase_t                 p_phase = PH_IDLE;
  logic [63:0]            p_acc   = 64'd0;
  logic                   p_neg   = 1'b0;
  logic [5:0]             p_radix = 6'd0;
  logic [OFFSET_BITS-1:0] p_count = '0;
  parse_res_t             pred_res;

  string_to_long_parser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .first     (first),
    .base      (base),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .end_offset(end_offset)
  );

  always #1 clk = ~clk;

  // Map a character to its digit value; 127 when it is not alphanumeric
  function automatic logic [6:0] char_digit(logic [7:0] c);
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      return 7'(c - CH_ZERO);
    end
    if (c inside {[CH_LC_A:CH_LC_Z]}) begin
      return 7'(c - CH_LC_A) + 7'd10;
    end
    if (c inside {[CH_UC_A:CH_UC_Z]}) begin
      return 7'(c - CH_UC_A) + 7'd10;
    end
    return DIGIT_NONE;
  endfunction

  // Advance the offset, holding at the saturation value
  function automatic void bump_count();
    if (p_count != COUNT_MAX) begin
      p_count = p_count + 1'b1;
    end
  endfunction

  // Accumulate a digit, or stop the parse and produce the result
  function automatic bit digit_step(logic [7:0] c, output parse_res_t r);
    logic [6:0] d;
    d = char_digit(c);
    r = '0;
    if (d < {1'b0, p_radix}) begin
      p_acc = p_acc * 64'(p_radix) + 64'(d);
      bump_count();
      p_phase = PH_DIGITS;
      return 1'b0;
    end
    r.value      = p_neg ? 64'd0 - p_acc : p_acc;
    r.end_offset = 16'(p_count);
    p_phase      = PH_IDLE;
    return 1'b1;
  endfunction

  // Handle the position where a radix prefix may start
  function automatic bit prefix_step(logic [7:0] c, output parse_res_t r);
    r = '0;
    if (c == CH_ZERO && (p_radix == RADIX_AUTO || p_radix == RADIX_HEX)) begin
      bump_count();
      p_phase = PH_ZERO;
      return 1'b0;
    end
    if (p_radix == RADIX_AUTO) begin
      p_radix = RADIX_DEC;
    end
    return digit_step(c, r);
  endfunction

  // Advance the parser by one request; return 1 when it yields a result
  function automatic bit parse_char(char_req_t q, output parse_res_t r);
    r = '0;
    if (q.first) begin
      p_phase = PH_LEAD;
      p_acc   = 64'd0;
      p_neg   = 1'b0;
      p_radix = q.base;
      p_count = '0;
    end
    case (p_phase)
      PH_LEAD: begin
        if (q.ch inside {CH_SPACE, CH_TAB, CH_LF}) begin
          bump_count();
          return 1'b0;
        end
        if (q.ch inside {CH_MINUS, CH_PLUS}) begin
          p_neg = (q.ch == CH_MINUS);
          bump_count();
          p_phase = PH_PREFIX;
          return 1'b0;
        end
        return prefix_step(q.ch, r);
      end
      PH_PREFIX: return prefix_step(q.ch, r);
      PH_ZERO: begin
        if (q.ch inside {CH_LC_X, CH_UC_X}) begin
          p_radix = RADIX_HEX;
          bump_count();
          p_phase = PH_DIGITS;
          return 1'b0;
        end
        if (p_radix == RADIX_AUTO) begin
          p_radix = RADIX_OCT;
        end
        return digit_step(q.ch, r);
      end
      PH_DIGITS: return digit_step(q.ch, r);
      default: return 1'b0;
    endcase
  endfunction

  // Queue one character; the first one of a string carries the radix
  function automatic void queue_char(logic [7:0] c);
    char_req_t q;
    q.ch    = c;
    q.first = start_next;
    q.base  = start_next ? cur_base : 6'($urandom);
    pending_chars.push_back(q);
    queued_count++;
    start_next = 1'b0;
  endfunction

  function automatic void add_text(string s, logic [5:0] b, logic [7:0] stop);
    start_next = 1'b1;
    cur_base   = b;
    foreach (s[i]) begin
      queue_char(s[i]);
    end
    queue_char(stop);
  endfunction

  // Build one mostly well-formed string with random content
  function automatic void add_random_string();
    int         eff;
    int         lim;
    int         v;
    int         n;
    int         pfx;
    logic [7:0] c;
    // some noise: stray characters, sometimes ignored while idle
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 1)) queue_char(8'($urandom));
    end
    case ($urandom_range(9))
      0, 1, 2: cur_base = RADIX_AUTO;
      3:       cur_base = RADIX_DEC;
      4:       cur_base = RADIX_HEX;
      5:       cur_base = RADIX_OCT;
      6:       cur_base = 6'd2;
      7:       cur_base = 6'd36;
      8:       cur_base = 6'($urandom_range(63, 1));
      default: cur_base = 6'($urandom_range(63));
    endcase
    start_next = 1'b1;
    repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) begin
      case ($urandom_range(2))
        0:       queue_char(CH_SPACE);
        1:       queue_char(CH_TAB);
        default: queue_char(CH_LF);
      endcase
    end
    case ($urandom_range(2))
      1:       queue_char(CH_PLUS);
      2:       queue_char(CH_MINUS);
      default: ;
    endcase
    eff = int'(cur_base);
    if (cur_base == RADIX_AUTO || cur_base == RADIX_HEX) begin
      pfx = $urandom_range(3);
      if (pfx <= 2) begin
        queue_char(CH_ZERO);
      end
      if (pfx == 0) begin
        queue_char(CH_LC_X);
      end else if (pfx == 1) begin
        queue_char(CH_UC_X);
      end
      if (cur_base == RADIX_AUTO) begin
        eff = (pfx <= 1) ? 16 : (pfx == 2) ? 8 : 10;
      end
    end
    lim = (eff > 36) ? 36 : eff;
    n = ($urandom_range(7) == 0) ? $urandom_range(30, 10) : $urandom_range(6);
    repeat (n) begin
      v = $urandom_range(lim - 1);
      if (v < 10) begin
        c = CH_ZERO + 8'(v);
      end else begin
        c = (($urandom_range(1) != 0) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
      end
      queue_char(c);
    end
    // stop on NUL or any byte; a byte that is still a digit leaves it open
    if ($urandom_range(1) == 0) begin
      queue_char(8'h00);
    end else begin
      queue_char(8'($urandom_range(255)));
    end
  endfunction

  function automatic void fill_random(int count);
    int target;
    target = queued_count + count;
    while (queued_count < target) begin
      add_random_string();
    end
  endfunction

  function automatic void note_failure(string msg);
    if (n_mismatch < 10) begin
      $display("ERROR: %s", msg);
    end
    n_mismatch++;
  endfunction

  // Wait until every request is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Drive requests and the result-side ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          ch       <= pending_chars[0].ch;
          first    <= pending_chars[0].first;
          base     <= pending_chars[0].base;
          void'(pending_chars.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict on accepted requests, check results, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      in_taken     <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        if (parse_char('{ch: ch, first: first, base: base}, pred_res)) begin
          expected_results.push_back(pred_res);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result value=%0d end_offset=%0d",
                                 value, end_offset));
        end else begin
          if (value !== expected_results[0].value ||
              end_offset !== expected_results[0].end_offset) begin
            note_failure($sformatf("value exp %0d got %0d, end_offset exp %0d got %0d",
                                   expected_results[0].value, value,
                                   expected_results[0].end_offset, end_offset));
          end
          void'(expected_results.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 53;

    // directed strings
    queue_char(8'h35);                          // no string active: ignored
    add_text(" \t\n-0x1F", RADIX_AUTO, 8'h00);  // blanks, sign, detected hex
    add_text("0x", RADIX_HEX, 8'h67);           // hex prefix then a non-digit
    add_text("017", RADIX_AUTO, 8'h39);         // lone zero selects octal
    add_text("12", RADIX_DEC, 8'h33);           // dropped by the restart below
    add_text("+z", 6'd36, 8'hFF);
    add_text("00", 6'd1, 8'h31);                // radix one takes only zeros
    add_text("zZ", 6'd63, 8'h00);               // radix above 36
    fill_random(340);

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    drain();

    // swap the idle rates after a full pause of the sender
    send_idle_pct = 53;
    recv_idle_pct = 15;
    fill_random(330);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(330);
    fill_random(20);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
design/stlp_pkg.sv
design/stlp_front.sv
design/stlp_queue.sv
design/stlp_back.sv
design/string_to_long_parser_top.sv
test/tb_string_to_long_parser_top.sv
